/* rtl/core/life_grid_engine_unit_defines.svh */
// Assertion helpers used by the checker file.
`ifndef LIFE_GRID_ENGINE_UNIT_DEFINES_SVH
`define LIFE_GRID_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LGE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("life grid engine: property violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LGE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("life grid engine: property violated");

`endif

/* rtl/core/lge_pkg.sv */
`timescale 1ns / 1ps

package lge_pkg;

  localparam int unsigned GRID_COLS_DEF = 64;
  localparam int unsigned GRID_ROWS_DEF = 64;

  // Stream payload layout
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned COL_LSB   = 0;
  localparam int unsigned ROW_LSB   = COL_LSB + COORD_W;
  localparam int unsigned ADJ_BIT   = ROW_LSB + COORD_W;

  localparam int unsigned CNT_W = 4;

  // B3/S23
  localparam logic [CNT_W-1:0] BIRTH_CNT   = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_CNT = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_ALIVE = 2'd0,
    CMD_SET_DEAD  = 2'd1,
    CMD_RUN_GEN   = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  // Center, then the eight neighbors row by row, then end of walk
  typedef enum logic [3:0] {
    POS_CTR,
    POS_UL,
    POS_UC,
    POS_UR,
    POS_ML,
    POS_MR,
    POS_DL,
    POS_DC,
    POS_DR,
    POS_END
  } pos_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_CTR_RD,
    ST_CTR_UPD,
    ST_NBR,
    ST_GEN_A,
    ST_GB_RD,
    ST_GB_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             live;
    logic             nxt;
    logic [CNT_W-1:0] cnt;
  } cell_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

/* rtl/core/lge_cell_mem.sv */
`timescale 1ns / 1ps

module lge_cell_mem import lge_pkg::*; #(
  parameter  int unsigned DEPTH = GRID_COLS_DEF * GRID_ROWS_DEF,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AddrW-1:0] waddr_i,
  input  cell_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output cell_t            rdata_o
);

  cell_t mem_q [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/lge_addr_gen.sv */
`timescale 1ns / 1ps

// Wrapped address of the center or one neighbor of the cursor cell.
module lge_addr_gen import lge_pkg::*; #(
  parameter  int unsigned GRID_COLS = GRID_COLS_DEF,
  parameter  int unsigned GRID_ROWS = GRID_ROWS_DEF,
  localparam int unsigned CellTotal = GRID_COLS * GRID_ROWS,
  localparam int unsigned AddrW     = $clog2(CellTotal),
  localparam int unsigned ColW      = $clog2(GRID_COLS)
) (
  input  logic [ColW-1:0]  col_i,
  input  logic [AddrW-1:0] rbase_i,
  input  pos_e             pos_i,
  output logic [AddrW-1:0] addr_o
);

  localparam logic [AddrW-1:0] LastRowBase = AddrW'(CellTotal - GRID_COLS);
  localparam logic [AddrW-1:0] RowStep     = AddrW'(GRID_COLS);
  localparam logic [ColW-1:0]  LastCol     = ColW'(GRID_COLS - 1);

  logic [ColW-1:0]  col_l, col_r, col_sel;
  logic [AddrW-1:0] rb_up, rb_dn, rb_sel;

  always_comb begin
    col_l = (col_i == '0) ? LastCol : col_i - ColW'(1);
    col_r = (col_i == LastCol) ? '0 : col_i + ColW'(1);
    rb_up = (rbase_i == '0) ? LastRowBase : rbase_i - RowStep;
    rb_dn = (rbase_i == LastRowBase) ? '0 : rbase_i + RowStep;

    unique case (pos_i)
      POS_UL: begin rb_sel = rb_up;   col_sel = col_l; end
      POS_UC: begin rb_sel = rb_up;   col_sel = col_i; end
      POS_UR: begin rb_sel = rb_up;   col_sel = col_r; end
      POS_ML: begin rb_sel = rbase_i; col_sel = col_l; end
      POS_MR: begin rb_sel = rbase_i; col_sel = col_r; end
      POS_DL: begin rb_sel = rb_dn;   col_sel = col_l; end
      POS_DC: begin rb_sel = rb_dn;   col_sel = col_i; end
      POS_DR: begin rb_sel = rb_dn;   col_sel = col_r; end
      default: begin rb_sel = rbase_i; col_sel = col_i; end
    endcase

    addr_o = rb_sel + AddrW'(col_sel);
  end

endmodule

/* rtl/core/lge_seq.sv */
`timescale 1ns / 1ps

module lge_seq import lge_pkg::*; #(
  parameter  int unsigned GRID_COLS = GRID_COLS_DEF,
  parameter  int unsigned GRID_ROWS = GRID_ROWS_DEF,
  localparam int unsigned CellTotal = GRID_COLS * GRID_ROWS,
  localparam int unsigned AddrW     = $clog2(CellTotal),
  localparam int unsigned ColW      = $clog2(GRID_COLS),
  localparam int unsigned RowW      = $clog2(GRID_ROWS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cmd_e               in_cmd_i,
  input  logic [COORD_W-1:0] in_col_i,
  input  logic [COORD_W-1:0] in_row_i,
  input  logic               in_adj_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_alive_o,
  output logic [CNT_W-1:0]   out_count_o,
  output logic               out_next_o,
  output logic [ColW-1:0]    cur_col_o,
  output logic [AddrW-1:0]   cur_rbase_o,
  output pos_e               pos_o,
  input  logic [AddrW-1:0]   nbr_addr_i,
  output mem_ctl_t           mem_ctl_o,
  output logic [AddrW-1:0]   mem_waddr_o,
  output logic [AddrW-1:0]   mem_raddr_o,
  output cell_t              mem_wdata_o,
  input  cell_t              mem_rdata_i
);

  localparam int unsigned  CoordN      = 2 ** COORD_W;
  localparam logic [AddrW:0] ScanEnd   = (AddrW + 1)'(CellTotal);
  localparam logic [AddrW:0] ScanLast  = (AddrW + 1)'(CellTotal - 1);
  localparam logic [AddrW-1:0] LastRowBase = AddrW'(CellTotal - GRID_COLS);
  localparam logic [AddrW-1:0] RowStep     = AddrW'(GRID_COLS);
  localparam logic [ColW-1:0]  LastCol     = ColW'(GRID_COLS - 1);

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic             adj_q, adj_d;
  logic [ColW-1:0]  tgt_col_q, tgt_col_d;
  logic [RowW-1:0]  tgt_row_q, tgt_row_d;
  logic [AddrW-1:0] tgt_rbase_q, tgt_rbase_d;
  logic [ColW-1:0]  cur_col_q, cur_col_d;
  logic [AddrW-1:0] cur_rbase_q, cur_rbase_d;
  pos_e             pos_q, pos_d;
  logic [AddrW:0]   scan_q, scan_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  cell_t            res_q, res_d;
  cell_t            out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // Input coordinates reduced modulo the grid size
  logic [ColW-1:0] col_mod [CoordN];
  logic [RowW-1:0] row_mod [CoordN];

  for (genvar gi = 0; gi < CoordN; gi++) begin : g_mod
    localparam int unsigned ColRem = gi % GRID_COLS;
    localparam int unsigned RowRem = gi % GRID_ROWS;
    assign col_mod[gi] = ColW'(ColRem);
    assign row_mod[gi] = RowW'(RowRem);
  end

  logic             need_nbr;
  logic             is_gen;
  logic             last_cell;
  logic             out_free;
  logic             rule_next;
  logic [CNT_W-1:0] delta;
  logic [AddrW-1:0] row_base;

  always_comb begin
    need_nbr  = (cmd_q == CMD_SET_ALIVE) || ((cmd_q == CMD_SET_DEAD) && adj_q);
    is_gen    = (cmd_q == CMD_RUN_GEN);
    last_cell = (cur_col_q == LastCol) && (cur_rbase_q == LastRowBase);
    out_free  = !out_valid_q || out_ready_i;
    delta     = (cmd_q == CMD_SET_DEAD) ? {CNT_W{1'b1}} : CNT_W'(1);
    row_base  = AddrW'(tgt_row_q * GRID_COLS);
    if (mem_rdata_i.live) begin
      rule_next = (mem_rdata_i.cnt == SURVIVE_CNT) || (mem_rdata_i.cnt == BIRTH_CNT);
    end else begin
      rule_next = (mem_rdata_i.cnt == BIRTH_CNT);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (scan_q == ScanLast) state_d = ST_IDLE;
      ST_IDLE:    if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP:   state_d = is_gen ? ST_GEN_A : ST_CTR_RD;
      ST_CTR_RD:  state_d = ST_CTR_UPD;
      ST_CTR_UPD: state_d = need_nbr ? ST_NBR : ST_DONE;
      ST_NBR: begin
        if (pos_q == POS_END) begin
          if (!is_gen) state_d = ST_DONE;
          else         state_d = last_cell ? ST_CTR_RD : ST_GB_RD;
        end
      end
      ST_GEN_A:   if (scan_q == ScanEnd) state_d = ST_GB_RD;
      ST_GB_RD:   state_d = ST_GB_UPD;
      ST_GB_UPD: begin
        if (mem_rdata_i.nxt) state_d = ST_NBR;
        else                 state_d = last_cell ? ST_CTR_RD : ST_GB_RD;
      end
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_CLEAR;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cmd_d       = cmd_q;
    adj_d       = adj_q;
    tgt_col_d   = tgt_col_q;
    tgt_row_d   = tgt_row_q;
    tgt_rbase_d = tgt_rbase_q;
    cur_col_d   = cur_col_q;
    cur_rbase_d = cur_rbase_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    wr_addr_d   = wr_addr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_ctl_o   = '0;
    mem_raddr_o = nbr_addr_i;
    mem_waddr_o = wr_addr_q;
    mem_wdata_o = mem_rdata_i;
    in_ready_o  = 1'b0;

    unique case (state_q) inside
      ST_CLEAR: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = scan_q[AddrW-1:0];
        mem_wdata_o     = '0;
        scan_d          = scan_q + (AddrW + 1)'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d     = in_cmd_i;
          adj_d     = in_adj_i;
          tgt_col_d = col_mod[in_col_i];
          tgt_row_d = row_mod[in_row_i];
        end
      end
      ST_SETUP: begin
        tgt_rbase_d = row_base;
        cur_rbase_d = row_base;
        cur_col_d   = tgt_col_q;
        pos_d       = POS_CTR;
        scan_d      = '0;
      end
      ST_CTR_RD, ST_GB_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        wr_addr_d       = nbr_addr_i;
        pos_d           = POS_UL;
      end
      ST_CTR_UPD: begin
        res_d = mem_rdata_i;
        if (cmd_q == CMD_SET_ALIVE) res_d.live = 1'b1;
        if (cmd_q == CMD_SET_DEAD)  res_d.live = 1'b0;
        mem_ctl_o.wr_en = (cmd_q == CMD_SET_ALIVE) || (cmd_q == CMD_SET_DEAD);
        mem_wdata_o     = res_d;
        if (need_nbr) begin
          mem_ctl_o.rd_en = 1'b1;
          wr_addr_d       = nbr_addr_i;
          pos_d           = POS_UC;
        end
      end
      ST_NBR: begin
        // write back the neighbor read last cycle while the next one is read
        mem_ctl_o.wr_en = 1'b1;
        mem_wdata_o.cnt = mem_rdata_i.cnt + delta;
        if (pos_q != POS_END) begin
          mem_ctl_o.rd_en = 1'b1;
          wr_addr_d       = nbr_addr_i;
          pos_d           = pos_e'(4'(pos_q + 4'd1));
        end else if (is_gen) begin
          pos_d = POS_CTR;
          if (last_cell) begin
            cur_col_d   = tgt_col_q;
            cur_rbase_d = tgt_rbase_q;
          end else if (cur_col_q == LastCol) begin
            cur_col_d   = '0;
            cur_rbase_d = cur_rbase_q + RowStep;
          end else begin
            cur_col_d = cur_col_q + ColW'(1);
          end
        end
      end
      ST_GEN_A: begin
        // rule sweep: read one cell, write the one read the cycle before
        mem_ctl_o.wr_en = (scan_q != '0);
        mem_wdata_o.nxt = rule_next;
        mem_wdata_o.cnt = '0;
        if (scan_q != ScanEnd) begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = scan_q[AddrW-1:0];
          wr_addr_d       = scan_q[AddrW-1:0];
          scan_d          = scan_q + (AddrW + 1)'(1);
        end else begin
          cur_col_d   = '0;
          cur_rbase_d = '0;
          pos_d       = POS_CTR;
        end
      end
      ST_GB_UPD: begin
        mem_ctl_o.wr_en  = 1'b1;
        mem_wdata_o.live = mem_rdata_i.nxt;
        if (mem_rdata_i.nxt) begin
          mem_ctl_o.rd_en = 1'b1;
          wr_addr_d       = nbr_addr_i;
          pos_d           = POS_UC;
        end else begin
          pos_d = POS_CTR;
          if (last_cell) begin
            cur_col_d   = tgt_col_q;
            cur_rbase_d = tgt_rbase_q;
          end else if (cur_col_q == LastCol) begin
            cur_col_d   = '0;
            cur_rbase_d = cur_rbase_q + RowStep;
          end else begin
            cur_col_d = cur_col_q + ColW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        mem_ctl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pos_q       <= POS_CTR;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    adj_q       <= adj_d;
    tgt_col_q   <= tgt_col_d;
    tgt_row_q   <= tgt_row_d;
    tgt_rbase_q <= tgt_rbase_d;
    cur_col_q   <= cur_col_d;
    cur_rbase_q <= cur_rbase_d;
    wr_addr_q   <= wr_addr_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_alive_o = out_q.live;
  assign out_count_o = out_q.cnt;
  assign out_next_o  = out_q.nxt;
  assign cur_col_o   = cur_col_q;
  assign cur_rbase_o = cur_rbase_q;
  assign pos_o       = pos_q;

endmodule

/* rtl/core/life_grid_engine_unit.sv */
`timescale 1ns / 1ps

// Toroidal B3/S23 Life engine. Each cell of the GRID_COLS x GRID_ROWS grid holds a live bit, a
// next-state bit and a 4-bit wrapping neighbor count in one single-port-per-direction memory
// (one read and one write a cycle), and every command walks that memory under a small
// sequencer; s_axis_tready is high only while the engine is idle, and one result beat follows
// each command. Read and set-dead without adjust pass through setup, a center read and a
// center update before the result; set alive and set dead with adjust add a read-modify-write
// of each of the eight neighbors. A generation sweeps the whole grid to set each next-state
// bit and clear the counts, then visits every cell in order to commit its live bit and, for
// each live cell, re-add its eight neighbor counts, and then reports the addressed cell. A
// previous result beat still held by m_axis_tready keeps the engine in its done state until
// that beat is taken. After reset a clearing pass clears every cell before the first command
// is taken. col and row are reduced modulo the grid size.
module life_grid_engine_unit import lge_pkg::*; #(
  parameter int unsigned GRID_COLS = GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // col[5:0], row[11:6], adjust_neighbors[12]
  input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // cell_alive[0], neighbor_count[4:1], next_alive[5]
);

  localparam int unsigned CellTotal = GRID_COLS * GRID_ROWS;
  localparam int unsigned AddrW     = $clog2(CellTotal);
  localparam int unsigned ColW      = $clog2(GRID_COLS);

  logic [ColW-1:0]  cur_col;
  logic [AddrW-1:0] cur_rbase;
  pos_e             pos;
  logic [AddrW-1:0] nbr_addr;
  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  cell_t            mem_wdata, mem_rdata;
  logic             res_alive, res_next;
  logic [CNT_W-1:0] res_count;

  lge_seq #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd_e'(s_axis_tuser)),
    .in_col_i    (s_axis_tdata[COL_LSB +: COORD_W]),
    .in_row_i    (s_axis_tdata[ROW_LSB +: COORD_W]),
    .in_adj_i    (s_axis_tdata[ADJ_BIT]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_alive_o (res_alive),
    .out_count_o (res_count),
    .out_next_o  (res_next),
    .cur_col_o   (cur_col),
    .cur_rbase_o (cur_rbase),
    .pos_o       (pos),
    .nbr_addr_i  (nbr_addr),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_raddr_o (mem_raddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  lge_addr_gen #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_addr_gen (
    .col_i   (cur_col),
    .rbase_i (cur_rbase),
    .pos_i   (pos),
    .addr_o  (nbr_addr)
  );

  lge_cell_mem #(
    .DEPTH (CellTotal)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata = {{(M_TDATA_W - CNT_W - 2){1'b0}}, res_next, res_count, res_alive};

endmodule

/* rtl/core/lge_checker.sv */
`timescale 1ns / 1ps
`include "life_grid_engine_unit_defines.svh"

module lge_checker import lge_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result beat stays up with its payload
  `LGE_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `LGE_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // one command at a time: ready drops right after an accepted beat
  `LGE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a fresh result appears as the engine returns to idle
  `LGE_ASSERT_IMP(a_result_at_idle, clk_i, rst_ni, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind life_grid_engine_unit lge_checker u_lge_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lge_pkg::*;

  localparam int unsigned COLS      = GRID_COLS_DEF;
  localparam int unsigned ROWS      = GRID_ROWS_DEF;
  localparam int unsigned CELLS     = COLS * ROWS;
  localparam int unsigned HANG_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 50;

  typedef struct packed {
    logic             alive;
    logic [CNT_W-1:0] count;
    logic             nxt;
  } cell_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // col[5:0], row[11:6], adjust_neighbors[12]
  logic [CMD_W-1:0]     s_axis_tuser = '0;  // cmd[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // cell_alive[0], neighbor_count[4:1], next_alive[5]

  // Shadow copy of the grid
  logic             grid_live [CELLS] = '{default: 1'b0};
  logic [CNT_W-1:0] grid_cnt  [CELLS] = '{default: '0};
  logic             grid_next [CELLS] = '{default: 1'b0};

  cell_report_t pending_reports [$];
  int           error_count = 0;
  int           items_sent = 0;
  int           stall_cycles = 0;
  int           ready_hold = 0;
  bit           idle_on = 1'b1;

  life_grid_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic void bump_around(int c, int r, logic [CNT_W-1:0] delta);
    int idx;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          idx = ((r + dr + ROWS) % ROWS) * COLS + ((c + dc + COLS) % COLS);
          grid_cnt[idx] = grid_cnt[idx] + delta;
        end
      end
    end
  endfunction

  function automatic void step_generation();
    logic [CNT_W-1:0] n;
    for (int idx = 0; idx < CELLS; idx++) begin
      n = grid_cnt[idx];
      if (grid_live[idx]) begin
        grid_next[idx] = (n == SURVIVE_CNT) || (n == BIRTH_CNT);
      end else begin
        grid_next[idx] = (n == BIRTH_CNT);
      end
      grid_cnt[idx] = '0;
    end
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        grid_live[r * COLS + c] = grid_next[r * COLS + c];
        if (grid_next[r * COLS + c]) bump_around(c, r, 4'd1);
      end
    end
  endfunction

  function automatic cell_report_t apply_command(cmd_e cmd, logic [COORD_W-1:0] col,
                                                 logic [COORD_W-1:0] row, logic adj);
    int c;
    int r;
    int idx;
    cell_report_t rep;
    c   = col % COLS;
    r   = row % ROWS;
    idx = r * COLS + c;
    case (cmd)
      CMD_SET_ALIVE: begin
        grid_live[idx] = 1'b1;
        bump_around(c, r, 4'd1);
      end
      CMD_SET_DEAD: begin
        grid_live[idx] = 1'b0;
        if (adj) bump_around(c, r, 4'hF);
      end
      CMD_RUN_GEN: step_generation();
      CMD_READ: ;
    endcase
    rep.alive = grid_live[idx];
    rep.count = grid_cnt[idx];
    rep.nxt   = grid_next[idx];
    return rep;
  endfunction

  task automatic send_cmd(input cmd_e cmd, input logic [COORD_W-1:0] col,
                          input logic [COORD_W-1:0] row, input logic adj);
    logic [S_TDATA_W-1:0] beat;
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat = '0;
    beat[COL_LSB +: COORD_W] = col;
    beat[ROW_LSB +: COORD_W] = row;
    beat[ADJ_BIT]            = adj;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_reports.push_back(apply_command(cmd, col, row, adj));
    items_sent++;
  endtask

  function automatic cmd_e pick_cmd(int gen_pct);
    int p;
    p = $urandom_range(0, 99);
    if (p < gen_pct) return CMD_RUN_GEN;
    if (p < 45) return CMD_SET_ALIVE;
    if (p < 72) return CMD_SET_DEAD;
    return CMD_READ;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      error_count++;
    end
  endtask

  // Output side: random backpressure, result check, hang watchdog
  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold    <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tready && $urandom_range(0, 5) == 0) begin
      ready_hold    <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cell_report_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("cell_alive", want.alive, m_axis_tdata[0]);
        check_field("neighbor_count", want.count, m_axis_tdata[4:1]);
        check_field("next_alive", want.nxt, m_axis_tdata[5]);
      end
    end
    if (rst_ni && !(m_axis_tvalid && m_axis_tready) && !(s_axis_tvalid && s_axis_tready)) begin
      stall_cycles++;
    end else begin
      stall_cycles = 0;
    end
    if (stall_cycles >= HANG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Corners wrap around the torus; counts wrap both ways.
  task automatic test_wrap_edges();
    send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0);
    send_cmd(CMD_SET_ALIVE, 6'd0, 6'd0, 1'b0);
    send_cmd(CMD_READ, 6'd63, 6'd63, 1'b0);
    send_cmd(CMD_READ, 6'd1, 6'd1, 1'b0);
    send_cmd(CMD_SET_ALIVE, 6'd0, 6'd0, 1'b1);  // repeat: neighbors bumped again
    send_cmd(CMD_SET_DEAD, 6'd0, 6'd0, 1'b0);   // live bit only
    send_cmd(CMD_SET_DEAD, 6'd0, 6'd0, 1'b1);
    send_cmd(CMD_READ, 6'd63, 6'd0, 1'b1);
    send_cmd(CMD_SET_DEAD, 6'd10, 6'd10, 1'b1); // neighbors go 0 -> 15
    send_cmd(CMD_READ, 6'd11, 6'd11, 1'b0);
    send_cmd(CMD_SET_ALIVE, 6'd10, 6'd10, 1'b0); // and 15 -> 0
    send_cmd(CMD_SET_DEAD, 6'd10, 6'd10, 1'b0);
    send_cmd(CMD_READ, 6'd63, 6'd63, 1'b1);
  endtask

  // Blinker across the right edge, two generations
  task automatic test_blinker();
    send_cmd(CMD_SET_ALIVE, 6'd63, 6'd20, 1'b0);
    send_cmd(CMD_SET_ALIVE, 6'd0, 6'd20, 1'b0);
    send_cmd(CMD_SET_ALIVE, 6'd1, 6'd20, 1'b1);
    send_cmd(CMD_RUN_GEN, 6'd0, 6'd21, 1'b1);
    send_cmd(CMD_READ, 6'd0, 6'd19, 1'b0);
    send_cmd(CMD_RUN_GEN, 6'd63, 6'd20, 1'b0);
    send_cmd(CMD_READ, 6'd1, 6'd20, 1'b0);
  endtask

  // Small colonies dropped into a 5x5 window, then evolved
  task automatic test_colony_growth(input int target);
    logic [COORD_W-1:0] base_c;
    logic [COORD_W-1:0] base_r;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;
    int n_cells;
    int n_gens;
    int p;
    while (items_sent < target) begin
      base_c  = COORD_W'($urandom_range(0, 63));
      base_r  = COORD_W'($urandom_range(0, 63));
      n_cells = $urandom_range(6, 20);
      repeat (n_cells) begin
        c = base_c + COORD_W'($urandom_range(0, 4));
        r = base_r + COORD_W'($urandom_range(0, 4));
        p = $urandom_range(0, 19);
        if (p < 15) send_cmd(CMD_SET_ALIVE, c, r, 1'($urandom_range(0, 1)));
        else if (p < 17) send_cmd(CMD_SET_DEAD, c, r, 1'b1);
        else if (p < 18) send_cmd(CMD_SET_DEAD, c, r, 1'b0);
        else send_cmd(CMD_READ, c, r, 1'($urandom_range(0, 1)));
      end
      n_gens = ($urandom_range(0, 2) == 0) ? 2 : 1;
      repeat (n_gens) begin
        send_cmd(CMD_RUN_GEN, base_c + COORD_W'($urandom_range(0, 4)),
                 base_r + COORD_W'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(2, 4)) begin
        send_cmd(CMD_READ, base_c + COORD_W'($urandom_range(0, 4)),
                 base_r + COORD_W'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_noise(input int n_items, input int gen_pct);
    repeat (n_items) begin
      send_cmd(pick_cmd(gen_pct), COORD_W'($urandom_range(0, 63)),
               COORD_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_noise(80, 1);
    send_cmd(CMD_RUN_GEN, 6'd63, 6'd0, 1'b1);
    send_cmd(CMD_READ, 6'd0, 6'd63, 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_wrap_edges();
    test_blinker();
    test_colony_growth(540);
    test_noise(100, 2);
    test_back_to_back();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lge_pkg.sv
rtl/core/lge_cell_mem.sv
rtl/core/lge_addr_gen.sv
rtl/core/lge_seq.sv
rtl/core/life_grid_engine_unit.sv
rtl/core/lge_checker.sv
verif/tb_top.sv
